// ===== sv/input_event_to_hid_report_defines.svh =====
// ----------------------------------------------------------------------------
// input_event_to_hid_report_defines.svh
// Assertion macros shared by the HID report builder.
// ----------------------------------------------------------------------------
`ifndef INPUT_EVENT_TO_HID_REPORT_DEFINES_SVH
`define INPUT_EVENT_TO_HID_REPORT_DEFINES_SVH

// condition holds at every clock edge outside reset
`define IEHR_ASSERT_NOW(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define IEHR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/iehr_pkg.sv =====
// ----------------------------------------------------------------------------
// iehr_pkg
// Types and constants of the HID keyboard and mouse report builder.
// ----------------------------------------------------------------------------
package iehr_pkg;

   localparam int SlotCount = 6;
   localparam int PackSlots = 6;
   localparam int PackCount = (SlotCount < PackSlots) ? SlotCount : PackSlots;
   localparam int NumFunc   = 8;
   localparam int FuncIdxW  = 3;
   localparam int CodeW     = 10;
   localparam int UsageW    = 8;
   localparam int ValueW    = 32;
   localparam int MoveW     = 8;
   localparam int ModW      = 8;
   localparam int BtnW      = 3;
   localparam int HitW      = 4;
   localparam int KeySlotsW = 48;
   localparam int ReqDataW  = 56;
   localparam int RspDataW  = 88;

   typedef logic [CodeW-1:0]    code_type;
   typedef logic [UsageW-1:0]   usage_type;
   typedef logic [FuncIdxW-1:0] func_idx_type;
   typedef usage_type [SlotCount-1:0] slot_array_type;

   typedef enum logic [1:0] {
      KIND_KEY   = 2'd0,
      KIND_MOUSE = 2'd1,
      KIND_TICK  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      CLASS_OTHER = 2'd0,
      CLASS_KEY   = 2'd1,
      CLASS_REL   = 2'd2
   } class_type;

   localparam logic [ValueW-1:0] KEY_RELEASE = 32'd0;
   localparam logic [ValueW-1:0] KEY_PRESS   = 32'd1;

   localparam code_type REL_X = 10'd0;
   localparam code_type REL_Y = 10'd1;

   localparam func_idx_type FUNC_FIRE    = 3'd0;
   localparam func_idx_type FUNC_FORWARD = 3'd7;

   localparam logic signed [ValueW-1:0] MOVE_MAX = 32'sd127;
   localparam logic signed [ValueW-1:0] MOVE_MIN = -32'sd127;

   // LCtrl, LShift, LAlt, LMeta, RCtrl, RShift, RAlt, RMeta
   localparam code_type ModCodes [ModW] = '{
      10'd29, 10'd42, 10'd56, 10'd125, 10'd97, 10'd54, 10'd100, 10'd126
   };
   // left, right, middle
   localparam code_type BtnCodes [BtnW] = '{10'd272, 10'd273, 10'd274};

   typedef struct packed {
      logic      press_en;
      logic      clear_en;
      usage_type usage;
   } slot_op_type;

   typedef struct packed {
      logic                 kbd_valid;
      logic                 mouse_valid;
      logic [ModW-1:0]      modifier_bits;
      logic [KeySlotsW-1:0] key_slots;
      logic [BtnW-1:0]      button_bits;
      logic [MoveW-1:0]     move_x;
      logic [MoveW-1:0]     move_y;
      logic [HitW-1:0]      function_hit;
      logic                 fire_flag;
      logic                 forward_enable;
   } rsp_type;

endpackage

// ===== sv/iehr_slot_update.sv =====
// ----------------------------------------------------------------------------
// iehr_slot_update
// Pressed-key slot search: fills the first empty slot on press, clears the
// first matching slot on release, flags any occupied slot.
// ----------------------------------------------------------------------------
module iehr_slot_update (
   input  iehr_pkg::slot_array_type slots_cur,
   input  iehr_pkg::slot_op_type    slot_op,
   output iehr_pkg::slot_array_type slots_next,
   output logic                     slots_busy
);
   import iehr_pkg::*;

   always_comb begin
      logic done;
      done       = 1'b0;
      slots_next = slots_cur;
      slots_busy = 1'b0;
      for (int i = 0; i < SlotCount; i++) begin
         if (slots_cur[i] != '0) begin
            slots_busy = 1'b1;
         end
         if (!done) begin
            if (slot_op.press_en && slots_cur[i] == '0) begin
               slots_next[i] = slot_op.usage;
               done          = 1'b1;
            end else if (slot_op.clear_en && slots_cur[i] == slot_op.usage) begin
               slots_next[i] = '0;
               done          = 1'b1;
            end
         end
      end
   end

endmodule

// ===== sv/input_event_to_hid_report.sv =====
// ----------------------------------------------------------------------------
// input_event_to_hid_report
// Builds boot-protocol HID keyboard and mouse reports from input events
// and report ticks; catches eight configurable function keys.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  req_      in   tvalid/tready      tuser kind, tdata event fields
//  rsp_      out  tvalid/tready      tuser valid flags, tdata report fields
//  csr_      in   we (no wait)       index 0..7, function key code
//
//  One item per cycle unless stalled; each result is registered on accept.
//  The state update and slot search resolve in the accept cycle.
//  Output register plus one skid entry: input stalls only when both are full.
//  Synchronous reset clears state and function key codes, not output data.
// ----------------------------------------------------------------------------
`include "input_event_to_hid_report_defines.svh"

module input_event_to_hid_report (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // class[1:0] code[11:2] value[43:12] usage[51:44] kbd_ready[52]
   // mouse_ready[53] link_up[54]
   input  logic [iehr_pkg::ReqDataW-1:0] req_tdata,
   // kind[1:0]
   input  logic [1:0]                    req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // modifier_bits[7:0] key_slots[55:8] button_bits[58:56] move_x[66:59]
   // move_y[74:67] function_hit[78:75] fire_flag[79] forward_enable[80]
   output logic [iehr_pkg::RspDataW-1:0] rsp_tdata,
   // kbd_valid[0] mouse_valid[1]
   output logic [1:0]                    rsp_tuser,
   input  logic                          csr_we,
   input  logic [iehr_pkg::FuncIdxW-1:0] csr_index,
   input  logic [iehr_pkg::CodeW-1:0]    csr_wdata
);
   import iehr_pkg::*;

   function automatic logic [MoveW-1:0] clamp_delta(input logic signed [ValueW-1:0] v);
      if (v > MOVE_MAX) begin
         return MOVE_MAX[MoveW-1:0];
      end else if (v < MOVE_MIN) begin
         return MOVE_MIN[MoveW-1:0];
      end
      return v[MoveW-1:0];
   endfunction

   // input fields
   logic [1:0]        ev_kind;
   logic [1:0]        ev_class;
   code_type          ev_code;
   logic [ValueW-1:0] ev_value;
   usage_type         ev_usage;
   logic              kbd_ready;
   logic              mouse_ready;
   logic              link_up;

   // state
   code_type          func_code_ff [NumFunc];
   logic              fwd_on_ff, fwd_on_in;
   logic              fire_on_ff, fire_on_in;
   logic [ModW-1:0]   mod_ff, mod_in;
   slot_array_type    slots_ff, slots_in;
   logic [BtnW-1:0]   btn_ff, btn_in;
   logic [MoveW-1:0]  sum_x_ff, sum_x_in;
   logic [MoveW-1:0]  sum_y_ff, sum_y_in;

   // output stage
   logic              out_valid_ff;
   rsp_type           out_data_ff;
   logic              skid_valid_ff;
   rsp_type           skid_data_ff;

   logic              req_accept;
   logic              out_free;
   rsp_type           rsp_in;
   slot_op_type       slot_op;
   logic              slots_busy;
   logic              func_match;
   func_idx_type      func_idx;
   logic              mod_match;
   logic [2:0]        mod_idx;
   logic [BtnW-1:0]   btn_mask;
   logic [ModW-1:0]   mod_bit;

   assign ev_kind     = req_tuser;
   assign ev_class    = req_tdata[1:0];
   assign ev_code     = req_tdata[11:2];
   assign ev_value    = req_tdata[43:12];
   assign ev_usage    = req_tdata[51:44];
   assign kbd_ready   = req_tdata[52];
   assign mouse_ready = req_tdata[53];
   assign link_up     = req_tdata[54];

   assign req_tready = !skid_valid_ff;
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !out_valid_ff || rsp_tready;

   iehr_slot_update u_slot_update (
      .slots_cur  (slots_ff),
      .slot_op    (slot_op),
      .slots_next (slots_in),
      .slots_busy (slots_busy)
   );

   // code matches; lowest function number wins
   always_comb begin
      func_match = 1'b0;
      func_idx   = '0;
      for (int i = NumFunc - 1; i >= 0; i--) begin
         if (func_code_ff[i] == ev_code) begin
            func_match = 1'b1;
            func_idx   = FuncIdxW'(i);
         end
      end
      mod_match = 1'b0;
      mod_idx   = '0;
      for (int i = ModW - 1; i >= 0; i--) begin
         if (ModCodes[i] == ev_code) begin
            mod_match = 1'b1;
            mod_idx   = 3'(i);
         end
      end
      for (int i = 0; i < BtnW; i++) begin
         btn_mask[i] = (BtnCodes[i] == ev_code);
      end
      mod_bit = ModW'(1) << mod_idx;
   end

   always_comb begin
      fwd_on_in  = fwd_on_ff;
      fire_on_in = fire_on_ff;
      mod_in     = mod_ff;
      btn_in     = btn_ff;
      sum_x_in   = sum_x_ff;
      sum_y_in   = sum_y_ff;
      slot_op    = '{press_en: 1'b0, clear_en: 1'b0, usage: ev_usage};
      rsp_in     = '0;
      case (kind_type'(ev_kind))
         KIND_KEY: begin
            if (ev_class == CLASS_KEY && func_match) begin
               if (ev_value == KEY_PRESS) begin
                  rsp_in.function_hit = HitW'({1'b0, func_idx}) + HitW'(1);
                  if (func_idx == FUNC_FIRE) begin
                     fire_on_in = !fire_on_ff;
                  end
                  if (func_idx == FUNC_FORWARD) begin
                     fwd_on_in = !fwd_on_ff;
                  end
               end
            end else if (fwd_on_ff && ev_class == CLASS_KEY) begin
               if (mod_match) begin
                  if (ev_value == KEY_PRESS) begin
                     mod_in = mod_ff | mod_bit;
                  end else if (ev_value == KEY_RELEASE) begin
                     mod_in = mod_ff & ~mod_bit;
                  end
               end else if (ev_usage != '0) begin
                  slot_op.press_en = (ev_value == KEY_PRESS);
                  slot_op.clear_en = (ev_value == KEY_RELEASE);
               end
            end
         end
         KIND_MOUSE: begin
            if (fwd_on_ff) begin
               if (ev_class == CLASS_KEY) begin
                  if (ev_value == KEY_PRESS) begin
                     btn_in = btn_ff | btn_mask;
                  end else if (ev_value == KEY_RELEASE) begin
                     btn_in = btn_ff & ~btn_mask;
                  end
               end else if (ev_class == CLASS_REL) begin
                  if (ev_code == REL_X) begin
                     sum_x_in = sum_x_ff + clamp_delta(ev_value);
                  end else if (ev_code == REL_Y) begin
                     sum_y_in = sum_y_ff + clamp_delta(ev_value);
                  end
               end
            end
         end
         KIND_TICK: begin
            sum_x_in = '0;
            sum_y_in = '0;
            if (fwd_on_ff && kbd_ready && link_up && (mod_ff != '0 || slots_busy)) begin
               rsp_in.kbd_valid     = 1'b1;
               rsp_in.modifier_bits = mod_ff;
               for (int i = 0; i < PackCount; i++) begin
                  rsp_in.key_slots[8*i +: 8] = slots_ff[i];
               end
            end
            if (mouse_ready && link_up &&
                (sum_x_ff != '0 || sum_y_ff != '0 || btn_ff != '0)) begin
               rsp_in.mouse_valid = 1'b1;
               rsp_in.button_bits = btn_ff;
               rsp_in.move_x      = sum_x_ff;
               rsp_in.move_y      = sum_y_ff;
            end
         end
         default: begin
         end
      endcase
      rsp_in.fire_flag      = fire_on_in;
      rsp_in.forward_enable = fwd_on_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumFunc; i++) begin
            func_code_ff[i] <= '0;
         end
         fwd_on_ff     <= 1'b0;
         fire_on_ff    <= 1'b0;
         mod_ff        <= '0;
         slots_ff      <= '0;
         btn_ff        <= '0;
         sum_x_ff      <= '0;
         sum_y_ff      <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            func_code_ff[csr_index] <= csr_wdata;
         end
         if (req_accept) begin
            fwd_on_ff  <= fwd_on_in;
            fire_on_ff <= fire_on_in;
            mod_ff     <= mod_in;
            slots_ff   <= slots_in;
            btn_ff     <= btn_in;
            sum_x_ff   <= sum_x_in;
            sum_y_ff   <= sum_y_in;
         end
         if (out_free) begin
            if (skid_valid_ff) begin
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end else begin
               out_valid_ff <= req_accept;
            end
         end else if (req_accept) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            out_data_ff <= skid_data_ff;
         end else if (req_accept) begin
            out_data_ff <= rsp_in;
         end
      end else if (req_accept) begin
         skid_data_ff <= rsp_in;
      end
   end

   assign rsp_tvalid        = out_valid_ff;
   assign rsp_tuser         = {out_data_ff.mouse_valid, out_data_ff.kbd_valid};
   assign rsp_tdata[7:0]    = out_data_ff.modifier_bits;
   assign rsp_tdata[55:8]   = out_data_ff.key_slots;
   assign rsp_tdata[58:56]  = out_data_ff.button_bits;
   assign rsp_tdata[66:59]  = out_data_ff.move_x;
   assign rsp_tdata[74:67]  = out_data_ff.move_y;
   assign rsp_tdata[78:75]  = out_data_ff.function_hit;
   assign rsp_tdata[79]     = out_data_ff.fire_flag;
   assign rsp_tdata[80]     = out_data_ff.forward_enable;
   assign rsp_tdata[87:81]  = '0;

   `IEHR_ASSERT_NOW(a_skid_behind_out, !skid_valid_ff || out_valid_ff, "skid item without output item")
   `IEHR_ASSERT_NEXT(a_tick_clears_sums, req_accept && ev_kind == KIND_TICK, sum_x_ff == '0 && sum_y_ff == '0, "sums not cleared by tick")
   `IEHR_ASSERT_NEXT(a_fire_holds_idle, !req_accept, $stable(fire_on_ff) && $stable(fwd_on_ff), "toggle flag moved without an item")
   `IEHR_ASSERT_NOW(a_kbd_needs_fwd, !(out_valid_ff && out_data_ff.kbd_valid) || out_data_ff.forward_enable, "keyboard report while forwarding off")

endmodule

// ===== sim/input_event_to_hid_report_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// input_event_to_hid_report_tb
// Self-checking bench for the HID keyboard and mouse report builder. Key,
// mouse and tick items go in with random gaps and output stalls; a local
// model of the builder predicts each report, and every report is compared
// field by field.
// ----------------------------------------------------------------------------
module input_event_to_hid_report_tb;
   import iehr_pkg::*;

   localparam logic [1:0]        KIND_UNUSED  = 2'd3;
   localparam logic [1:0]        CLASS_UNUSED = 2'd3;
   localparam logic [ValueW-1:0] KEY_REPEAT   = 32'd2;
   localparam int                KeyCodeBase  = 16;
   localparam int                MaxCode      = 767;
   localparam int                MaxPrinted   = 200;

   typedef struct packed {
      logic [1:0]        kind;
      logic [1:0]        cls;
      code_type          code;
      logic [ValueW-1:0] value;
      usage_type         usage;
      logic              kbd_ready;
      logic              mouse_ready;
      logic              link_up;
   } input_event_type;

   typedef code_type [NumFunc-1:0] code_set_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata;
   logic [1:0]          req_tuser;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RspDataW-1:0] rsp_tdata;
   logic [1:0]          rsp_tuser;
   logic                csr_we;
   func_idx_type        csr_index;
   code_type            csr_wdata;

   // model state
   code_type         key_codes [NumFunc];
   logic             fwd_en;
   logic             fire_en;
   logic [ModW-1:0]  mod_bits;
   usage_type        slot_usage [SlotCount];
   logic [BtnW-1:0]  btn_bits;
   logic [MoveW-1:0] acc_x;
   logic [MoveW-1:0] acc_y;

   rsp_type expected_reports [$];
   int      error_count = 0;
   int      gap_pct = 0;
   int      stall_pct = 0;

   input_event_to_hid_report dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [MoveW-1:0] clamp_move(input logic signed [ValueW-1:0] delta);
      if (delta > MOVE_MAX) return MOVE_MAX[MoveW-1:0];
      if (delta < MOVE_MIN) return MOVE_MIN[MoveW-1:0];
      return delta[MoveW-1:0];
   endfunction

   function automatic void clear_model();
      for (int i = 0; i < NumFunc; i++) key_codes[i] = '0;
      for (int i = 0; i < SlotCount; i++) slot_usage[i] = '0;
      fwd_en   = 1'b0;
      fire_en  = 1'b0;
      mod_bits = '0;
      btn_bits = '0;
      acc_x    = '0;
      acc_y    = '0;
   endfunction

   // updates the model with one item and returns the report it causes
   function automatic rsp_type apply_event(input input_event_type ev);
      rsp_type          rep;
      logic             caught;
      logic             is_mod;
      logic             done;
      logic             any_key;
      logic [MoveW-1:0] dx;
      logic [MoveW-1:0] dy;
      rep = '0;
      case (ev.kind)
         KIND_KEY: begin
            // function keys are caught first, lowest number wins
            caught = 1'b0;
            if (ev.cls == CLASS_KEY) begin
               for (int i = 0; i < NumFunc; i++) begin
                  if (!caught && key_codes[i] == ev.code) begin
                     caught = 1'b1;
                     if (ev.value == KEY_PRESS) begin
                        if (i == FUNC_FIRE) fire_en = !fire_en;
                        if (i == FUNC_FORWARD) fwd_en = !fwd_en;
                        rep.function_hit = HitW'(i + 1);
                     end
                  end
               end
            end
            if (!caught && fwd_en && ev.cls == CLASS_KEY) begin
               is_mod = 1'b0;
               for (int i = 0; i < ModW; i++) begin
                  if (ModCodes[i] == ev.code) begin
                     is_mod = 1'b1;
                     if (ev.value == KEY_PRESS) mod_bits[i] = 1'b1;
                     else if (ev.value == KEY_RELEASE) mod_bits[i] = 1'b0;
                  end
               end
               if (!is_mod && ev.usage != '0) begin
                  done = 1'b0;
                  for (int i = 0; i < SlotCount; i++) begin
                     if (!done && ev.value == KEY_PRESS && slot_usage[i] == '0) begin
                        slot_usage[i] = ev.usage;
                        done = 1'b1;
                     end else if (!done && ev.value == KEY_RELEASE &&
                                  slot_usage[i] == ev.usage) begin
                        slot_usage[i] = '0;
                        done = 1'b1;
                     end
                  end
               end
            end
         end
         KIND_MOUSE: begin
            if (fwd_en && ev.cls == CLASS_KEY) begin
               for (int i = 0; i < BtnW; i++) begin
                  if (BtnCodes[i] == ev.code) begin
                     if (ev.value == KEY_PRESS) btn_bits[i] = 1'b1;
                     else if (ev.value == KEY_RELEASE) btn_bits[i] = 1'b0;
                  end
               end
            end else if (fwd_en && ev.cls == CLASS_REL) begin
               if (ev.code == REL_X) acc_x = acc_x + clamp_move(ev.value);
               else if (ev.code == REL_Y) acc_y = acc_y + clamp_move(ev.value);
            end
         end
         KIND_TICK: begin
            dx = acc_x;
            dy = acc_y;
            acc_x = '0;
            acc_y = '0;
            any_key = (mod_bits != '0);
            for (int i = 0; i < SlotCount; i++)
               if (slot_usage[i] != '0) any_key = 1'b1;
            if (fwd_en && ev.kbd_ready && ev.link_up && any_key) begin
               rep.kbd_valid     = 1'b1;
               rep.modifier_bits = mod_bits;
               for (int i = 0; i < PackCount; i++)
                  rep.key_slots[UsageW*i +: UsageW] = slot_usage[i];
            end
            if (ev.mouse_ready && ev.link_up && (dx != '0 || dy != '0 || btn_bits != '0)) begin
               rep.mouse_valid = 1'b1;
               rep.button_bits = btn_bits;
               rep.move_x      = dx;
               rep.move_y      = dy;
            end
         end
         default: ;
      endcase
      rep.fire_flag      = fire_en;
      rep.forward_enable = fwd_en;
      return rep;
   endfunction

   task automatic check_field(input string name, input logic [KeySlotsW-1:0] want,
                              input logic [KeySlotsW-1:0] got);
      if (want !== got) begin
         if (error_count < MaxPrinted)
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         error_count++;
      end
   endtask

   // tracks register writes and accepted items, checks each report
   always @(posedge clock) begin : report_monitor
      input_event_type seen;
      rsp_type         want;
      if (reset) begin
         clear_model();
         expected_reports.delete();
      end else begin
         if (csr_we) key_codes[csr_index] = csr_wdata;
         if (req_tvalid && req_tready) begin
            seen.kind        = req_tuser;
            seen.cls         = req_tdata[1:0];
            seen.code        = req_tdata[11:2];
            seen.value       = req_tdata[43:12];
            seen.usage       = req_tdata[51:44];
            seen.kbd_ready   = req_tdata[52];
            seen.mouse_ready = req_tdata[53];
            seen.link_up     = req_tdata[54];
            expected_reports.push_back(apply_event(seen));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_reports.size() == 0) begin
               if (error_count < MaxPrinted) $error("report with no item pending");
               error_count++;
            end else begin
               want = expected_reports.pop_front();
               check_field("kbd_valid", KeySlotsW'(want.kbd_valid), KeySlotsW'(rsp_tuser[0]));
               check_field("mouse_valid", KeySlotsW'(want.mouse_valid),
                           KeySlotsW'(rsp_tuser[1]));
               check_field("modifier_bits", KeySlotsW'(want.modifier_bits),
                           KeySlotsW'(rsp_tdata[7:0]));
               check_field("key_slots", want.key_slots, rsp_tdata[55:8]);
               check_field("button_bits", KeySlotsW'(want.button_bits),
                           KeySlotsW'(rsp_tdata[58:56]));
               check_field("move_x", KeySlotsW'(want.move_x), KeySlotsW'(rsp_tdata[66:59]));
               check_field("move_y", KeySlotsW'(want.move_y), KeySlotsW'(rsp_tdata[74:67]));
               check_field("function_hit", KeySlotsW'(want.function_hit),
                           KeySlotsW'(rsp_tdata[78:75]));
               check_field("fire_flag", KeySlotsW'(want.fire_flag), KeySlotsW'(rsp_tdata[79]));
               check_field("forward_enable", KeySlotsW'(want.forward_enable),
                           KeySlotsW'(rsp_tdata[80]));
            end
         end
      end
   end

   initial begin : report_stall
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   function automatic input_event_type key_item(input logic [1:0] cls, input code_type code,
                                                input logic [ValueW-1:0] value,
                                                input usage_type usage);
      input_event_type ev;
      ev       = '0;
      ev.kind  = KIND_KEY;
      ev.cls   = cls;
      ev.code  = code;
      ev.value = value;
      ev.usage = usage;
      return ev;
   endfunction

   function automatic input_event_type mouse_item(input logic [1:0] cls, input code_type code,
                                                  input logic [ValueW-1:0] value);
      input_event_type ev;
      ev       = '0;
      ev.kind  = KIND_MOUSE;
      ev.cls   = cls;
      ev.code  = code;
      ev.value = value;
      return ev;
   endfunction

   function automatic input_event_type tick_item(input logic kbd_ready,
                                                 input logic mouse_ready,
                                                 input logic link_up);
      input_event_type ev;
      ev             = '0;
      ev.kind        = KIND_TICK;
      ev.kbd_ready   = kbd_ready;
      ev.mouse_ready = mouse_ready;
      ev.link_up     = link_up;
      return ev;
   endfunction

   task automatic send_item(input input_event_type ev);
      if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= ev.kind;
      req_tdata  <= {1'b0, ev.link_up, ev.mouse_ready, ev.kbd_ready, ev.usage, ev.value,
                     ev.code, ev.cls};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic wait_for_reports();
      int guard;
      req_tvalid <= 1'b0;
      guard = 0;
      repeat (2) @(posedge clock);
      while (expected_reports.size() != 0 && guard < 2000) begin
         @(posedge clock);
         guard++;
      end
      if (expected_reports.size() != 0) begin
         $error("%0d reports never arrived", expected_reports.size());
         error_count++;
         expected_reports.delete();
      end
      repeat (4) @(posedge clock);
   endtask

   // only while idle; an idle wait at the end lets the model catch the last write
   task automatic write_codes(input code_set_type codes);
      for (int i = 0; i < NumFunc; i++) begin
         csr_we    <= 1'b1;
         csr_index <= FuncIdxW'(i);
         csr_wdata <= codes[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic code_set_type spread_codes();
      code_set_type codes;
      for (int i = 0; i < NumFunc; i++)
         codes[i] = CodeW'($urandom_range(0, 95) + 96 * i);
      return codes;
   endfunction

   task automatic ensure_forwarding();
      if (!fwd_en) begin
         send_item(key_item(CLASS_KEY, key_codes[FUNC_FORWARD], KEY_PRESS, '0));
         wait_for_reports();
      end
   endtask

   function automatic input_event_type random_item();
      input_event_type ev;
      int              pick;
      ev             = '0;
      ev.code        = CodeW'($urandom_range(0, MaxCode));
      ev.value       = $urandom();
      ev.usage       = UsageW'($urandom());
      ev.kbd_ready   = $urandom_range(0, 6) != 0;
      ev.mouse_ready = $urandom_range(0, 6) != 0;
      ev.link_up     = $urandom_range(0, 9) != 0;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         ev.kind = KIND_KEY;
         ev.cls  = ($urandom_range(0, 19) == 0) ? 2'($urandom_range(0, 3)) : CLASS_KEY;
         pick = $urandom_range(0, 99);
         if (pick < 12) ev.code = key_codes[$urandom_range(0, NumFunc - 1)];
         else if (pick < 32) ev.code = ModCodes[$urandom_range(0, ModW - 1)];
         else if (pick < 85) ev.code = CodeW'(KeyCodeBase + $urandom_range(0, 9));
         pick = $urandom_range(0, 99);
         if (pick < 90) ev.usage = ev.code[UsageW-1:0] + 8'd1;
         else if (pick < 95) ev.usage = '0;
         pick = $urandom_range(0, 99);
         if (pick < 48) ev.value = KEY_PRESS;
         else if (pick < 90) ev.value = KEY_RELEASE;
         else if (pick < 95) ev.value = KEY_REPEAT;
      end else if (pick < 75) begin
         ev.kind = KIND_MOUSE;
         if ($urandom_range(0, 1) == 0) begin
            ev.cls = CLASS_KEY;
            if ($urandom_range(0, 19) != 0) ev.code = BtnCodes[$urandom_range(0, BtnW - 1)];
            if ($urandom_range(0, 9) != 0)
               ev.value = ($urandom_range(0, 1) != 0) ? KEY_PRESS : KEY_RELEASE;
         end else begin
            ev.cls = CLASS_REL;
            if ($urandom_range(0, 19) != 0)
               ev.code = ($urandom_range(0, 1) != 0) ? REL_Y : REL_X;
            pick = $urandom_range(0, 99);
            if (pick < 70) ev.value = $urandom_range(0, 80) - 40;
            else if (pick < 78) ev.value = 32'd127 + $urandom_range(0, 1);
            else if (pick < 86) ev.value = -32'sd127 - $urandom_range(0, 1);
         end
         if ($urandom_range(0, 19) == 0) ev.cls = 2'($urandom_range(0, 3));
      end else if (pick < 97) begin
         ev.kind = KIND_TICK;
         ev.cls  = 2'($urandom_range(0, 3));
      end else begin
         ev.kind = KIND_UNUSED;
         ev.cls  = 2'($urandom_range(0, 3));
      end
      return ev;
   endfunction

   // all codes are zero after reset, so code 0 is the fire key
   task automatic test_reset_defaults();
      send_item(tick_item(1'b1, 1'b1, 1'b1));
      send_item(key_item(CLASS_KEY, '0, KEY_PRESS, '0));
      wait_for_reports();
   endtask

   task automatic test_function_keys();
      // index 0 in the lowest bits; forward toggle at the top code
      write_codes({10'd767, 10'd65, 10'd64, 10'd63, 10'd62, 10'd61, 10'd60, 10'd59});
      for (int i = 0; i < NumFunc; i++)
         send_item(key_item(CLASS_KEY, key_codes[i], KEY_PRESS, 8'd4));
      send_item(key_item(CLASS_KEY, key_codes[1], KEY_RELEASE, 8'd4));
      send_item(key_item(CLASS_KEY, key_codes[2], KEY_REPEAT, 8'd4));
      wait_for_reports();
   endtask

   task automatic test_keyboard();
      send_item(key_item(CLASS_KEY, ModCodes[0], KEY_PRESS, 8'hE0));
      send_item(key_item(CLASS_KEY, ModCodes[ModW-1], KEY_PRESS, '0));
      // seventh press finds the slots full
      for (int i = 0; i < 7; i++)
         send_item(key_item(CLASS_KEY, CodeW'(30 + i), KEY_PRESS,
                            (i == 6) ? 8'hFF : 8'(4 + i)));
      send_item(key_item(CLASS_KEY, 10'd30, KEY_REPEAT, 8'd4));
      send_item(key_item(CLASS_KEY, 10'd40, KEY_PRESS, '0));
      send_item(key_item(CLASS_KEY, 10'd41, KEY_RELEASE, 8'd100));
      send_item(key_item(CLASS_KEY, 10'd32, KEY_RELEASE, 8'd6));
      send_item(key_item(CLASS_UNUSED, 10'd33, KEY_PRESS, 8'd20));
      send_item(tick_item(1'b0, 1'b1, 1'b1));
      send_item(tick_item(1'b1, 1'b1, 1'b1));
      wait_for_reports();
   endtask

   task automatic test_mouse();
      input_event_type odd;
      odd      = tick_item(1'b1, 1'b1, 1'b1);
      odd.kind = KIND_UNUSED;
      send_item(mouse_item(CLASS_KEY, BtnCodes[0], KEY_PRESS));
      send_item(mouse_item(CLASS_REL, REL_X, 32'h7FFF_FFFF));
      send_item(mouse_item(CLASS_REL, REL_Y, 32'h8000_0000));
      send_item(mouse_item(CLASS_REL, 10'd2, 32'd50));
      // sums are cleared even when the report is held back
      send_item(tick_item(1'b1, 1'b0, 1'b1));
      send_item(mouse_item(CLASS_REL, REL_X, -32'sd5));
      send_item(tick_item(1'b1, 1'b1, 1'b1));
      send_item(odd);
      // buttons still report with forwarding off
      send_item(key_item(CLASS_KEY, key_codes[FUNC_FORWARD], KEY_PRESS, '0));
      send_item(mouse_item(CLASS_REL, REL_X, 32'd10));
      send_item(tick_item(1'b0, 1'b1, 1'b1));
      wait_for_reports();
   endtask

   task automatic test_random_traffic(input int count, input int gap, input int stall);
      gap_pct   = gap;
      stall_pct = stall;
      for (int n = 0; n < count; n++) begin
         send_item(random_item());
         if (n == count / 2) wait_for_reports();
      end
      wait_for_reports();
   endtask

   initial begin : stimulus
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      gap_pct    = 30;
      stall_pct  = 30;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_function_keys();
      test_keyboard();
      test_mouse();

      write_codes(spread_codes());
      ensure_forwarding();
      test_random_traffic(300, 20, 20);
      write_codes({NumFunc{10'd767}});
      test_random_traffic(250, 40, 10);
      write_codes({NumFunc{10'd0}});
      test_random_traffic(250, 10, 40);
      write_codes(spread_codes());
      ensure_forwarding();
      test_random_traffic(450, 0, 0);

      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+sv
sv/iehr_pkg.sv
sv/iehr_slot_update.sv
sv/input_event_to_hid_report.sv
sim/input_event_to_hid_report_tb.sv
